// ===== rtl/ack_range_coalescing_queue_defines.svh =====
`ifndef ACK_RANGE_COALESCING_QUEUE_DEFINES_SVH
`define ACK_RANGE_COALESCING_QUEUE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define ARCQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arcq check failed");

// next-cycle implication, sampled on clk, off during rst
`define ARCQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arcq check failed");

`endif

// ===== rtl/arcq_pkg.sv =====
`default_nettype none

package arcq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [7:0] SAT_EXTRA = 8'd255;

  localparam logic [1:0] CMD_RECORD = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CHECK  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] seq_num;
    logic [63:0] send_stamp;
  } cmd_item_t;

  typedef struct packed {
    logic        ack_valid;
    logic [31:0] ack_start;
    logic        has_extra;
    logic [7:0]  extra_count;
    logic [63:0] ack_stamp;
    logic        notify_ready;
    logic        queue_empty;
    logic        overflow;
  } ack_result_t;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] len;
    logic [63:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/arcq_chan_if.sv =====
`default_nettype none

interface arcq_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/arcq_ram.sv =====
`default_nettype none

module arcq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/arcq_ctrl.sv =====
`default_nettype none

`include "ack_range_coalescing_queue_defines.svh"

module arcq_ctrl
  import arcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(QUEUE_DEPTH),
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  arcq_chan_if.sink             req,
  arcq_chan_if.source           rsp,
  output mem_ctl_t              ctl,
  output logic      [PTR_W-1:0] rd_addr,
  output logic      [PTR_W-1:0] wr_addr,
  output entry_t                wr_entry,
  input  entry_t                rd_entry
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(QUEUE_DEPTH);

  logic              state;
  logic [PTR_W-1:0]  head;
  logic [PTR_W-1:0]  head_next;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  tail_next;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] fill_next;
  logic              ready_flag;
  logic              ready_flag_next;
  cmd_item_t         item;
  ack_result_t       result;
  ack_result_t       result_next;
  logic              result_valid;

  logic              accept;
  logic              step;
  logic [PTR_W-1:0]  last;
  logic              ext_hit;
  logic [31:0]       extra;

  assign req.ready   = (state == ST_IDLE);
  assign accept      = req.valid && req.ready;
  assign step        = (state == ST_EXEC) && (!result_valid || rsp.ready);
  assign rsp.valid   = result_valid;
  assign rsp.payload = result;

  assign last    = (tail == '0) ? LAST_SLOT : tail - PTR_W'(1);
  assign rd_addr = (req.payload.command == CMD_RECORD) ? last : head;
  assign ext_hit = (fill != '0) && (rd_entry.len != '1) &&
                   (item.seq_num == rd_entry.first + rd_entry.len);
  assign extra   = rd_entry.len - 32'd1;

  always_comb begin
    result_next     = '0;
    head_next       = head;
    tail_next       = tail;
    fill_next       = fill;
    ready_flag_next = ready_flag;
    ctl.rd_en       = accept;
    ctl.wr_en       = 1'b0;
    wr_addr         = last;
    wr_entry        = rd_entry;
    unique case (item.command)
      CMD_RECORD: begin
        if (ext_hit) begin
          ctl.wr_en    = step;
          wr_entry.len = rd_entry.len + 32'd1;
        end else if (fill == FULL) begin
          result_next.overflow = 1'b1;
        end else begin
          ctl.wr_en      = step;
          wr_addr        = tail;
          wr_entry.first = item.seq_num;
          wr_entry.len   = 32'd1;
          wr_entry.stamp = item.send_stamp;
          tail_next      = (tail == LAST_SLOT) ? '0 : tail + PTR_W'(1);
          fill_next      = fill + FILL_W'(1);
        end
        result_next.notify_ready = !ready_flag;
        ready_flag_next          = 1'b1;
      end
      CMD_POP: begin
        if (fill != '0) begin
          result_next.ack_valid = 1'b1;
          result_next.ack_start = rd_entry.first;
          result_next.ack_stamp = rd_entry.stamp;
          if (rd_entry.len > 32'd1) begin
            result_next.has_extra   = 1'b1;
            result_next.extra_count = (extra > 32'(SAT_EXTRA)) ? SAT_EXTRA : extra[7:0];
          end
          head_next = (head == LAST_SLOT) ? '0 : head + PTR_W'(1);
          fill_next = fill - FILL_W'(1);
        end
      end
      CMD_CHECK: begin
        if (fill == '0) begin
          ready_flag_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    result_next.queue_empty = (fill_next == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      head         <= '0;
      tail         <= '0;
      fill         <= '0;
      ready_flag   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        state <= ST_EXEC;
      end
      if (step) begin
        state        <= ST_IDLE;
        head         <= head_next;
        tail         <= tail_next;
        fill         <= fill_next;
        ready_flag   <= ready_flag_next;
        result_valid <= 1'b1;
      end else if (rsp.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // hold request and result payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req.payload;
    end
    if (step) begin
      result <= result_next;
    end
  end

  `ARCQ_ASSERT_IMPL(a_fill_bound, 1'b1, fill <= FULL)
  `ARCQ_ASSERT_IMPL(a_ptr_wrap, (fill == '0) || (fill == FULL), head == tail)
  `ARCQ_ASSERT_IMPL(a_write_in_exec, ctl.wr_en, state == ST_EXEC)
  `ARCQ_ASSERT_NEXT(a_accept_exec, accept, state == ST_EXEC)
  `ARCQ_ASSERT_NEXT(a_pop_drain, step && (item.command == CMD_POP) && (fill != '0),
                    fill == $past(fill) - FILL_W'(1))

endmodule

`default_nettype wire

// ===== rtl/ack_range_coalescing_queue.sv =====
`default_nettype none

// Pending-acknowledgement range queue. For each request, the accept cycle
// reads one queue entry (the newest range for a record, the oldest for a pop)
// from the single-port-read range RAM, and the execute state then compares,
// updates and writes that entry back and loads the result register; it waits
// there while the previous result is still unconsumed. A new request is taken
// once the write-back is done, even while the previous result still waits for
// its consumer, but not before. The range RAM is never cleared; only entries
// between the head and tail pointers are ever used.

module ack_range_coalescing_queue
  import arcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input wire logic    clk,
  input wire logic    rst,
  arcq_chan_if.sink   req,
  arcq_chan_if.source rsp
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  mem_ctl_t             ctl;
  logic     [PTR_W-1:0] rd_addr;
  logic     [PTR_W-1:0] wr_addr;
  entry_t               wr_entry;
  entry_t               rd_entry;
  logic   [ENTRY_W-1:0] rd_data;

  assign rd_entry = entry_t'(rd_data);

  arcq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_entry (rd_entry)
  );

  arcq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire
